/* hdl/msdp_pkg.sv */
package msdp_pkg;

   // field widths of the item formats
   localparam int COUNT_W = 4;
   localparam int MEAN_W  = 16;
   localparam int SUM_W   = 64;

   // fraction bits of a standardized value and of the sum
   localparam int ACC_FRAC = 24;

   // multiplier digit
   localparam int DIGIT_W = 8;

   localparam int MAX_COUNT_DEF = 8;
   localparam int FRAC_BITS_DEF = 12;

   localparam int NUM_W_DEF = $clog2(MAX_COUNT_DEF + 1) + FRAC_BITS_DEF;
   localparam int MAG_W_DEF = (NUM_W_DEF > MEAN_W) ? NUM_W_DEF : MEAN_W;
   localparam int SD_W_DEF  = (FRAC_BITS_DEF + 1 > MEAN_W) ? FRAC_BITS_DEF + 1 : MEAN_W;
   localparam int Z_W_DEF   = MAG_W_DEF + ACC_FRAC;

   localparam logic [SUM_W-1:0] POS_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic [SUM_W-1:0] NEG_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   typedef struct packed {
      logic [COUNT_W-1:0] x_count;
      logic [COUNT_W-1:0] y_count;
      logic               x_missing;
      logic               y_missing;
      logic [MEAN_W-1:0]  mean_value;
      logic [MEAN_W-1:0]  sd_value;
      logic               last_locus;
   } req_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] dot_product;
      logic                    saturated;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_ACC
   } state_type;

endpackage

/* hdl/msdp_div.sv */
module msdp_div
   import msdp_pkg::*;
#(
   parameter int MAG_W = MAG_W_DEF,
   parameter int SD_W  = SD_W_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [MAG_W-1:0]          mag_x,
   input  logic [MAG_W-1:0]          mag_y,
   input  logic [SD_W-1:0]           divisor,
   output logic                      done,
   output logic [MAG_W+ACC_FRAC-1:0] quot_x,
   output logic [MAG_W+ACC_FRAC-1:0] quot_y
);

   localparam int Z_W   = MAG_W + ACC_FRAC;
   localparam int CNT_W = $clog2(Z_W);

   // two restoring lanes sharing one divisor, one quotient bit per cycle
   logic [Z_W-1:0]   dvd_ff [2];
   logic [Z_W-1:0]   dvd_in [2];
   logic [SD_W-1:0]  rem_ff [2];
   logic [SD_W-1:0]  rem_in [2];
   logic [SD_W:0]    trial  [2];
   logic             ge     [2];
   logic [SD_W-1:0]  sd_ff;
   logic [SD_W-1:0]  sd_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             busy_ff;
   logic             busy_in;
   logic             done_ff;
   logic             done_in;

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         trial[i] = {rem_ff[i], dvd_ff[i][Z_W-1]};
         ge[i]    = (trial[i] >= {1'b0, sd_ff});
      end
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      sd_in   = sd_ff;
      for (int i = 0; i < 2; i++) begin
         dvd_in[i] = dvd_ff[i];
         rem_in[i] = rem_ff[i];
      end
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         sd_in     = divisor;
         dvd_in[0] = {mag_x, {ACC_FRAC{1'b0}}};
         dvd_in[1] = {mag_y, {ACC_FRAC{1'b0}}};
         rem_in[0] = '0;
         rem_in[1] = '0;
      end else if (busy_ff) begin
         for (int i = 0; i < 2; i++) begin
            rem_in[i] = ge[i] ? SD_W'(trial[i] - {1'b0, sd_ff}) : SD_W'(trial[i]);
            dvd_in[i] = {dvd_ff[i][Z_W-2:0], ge[i]};
         end
         if (cnt_ff == CNT_W'(Z_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sd_ff     <= sd_in;
      dvd_ff[0] <= dvd_in[0];
      dvd_ff[1] <= dvd_in[1];
      rem_ff[0] <= rem_in[0];
      rem_ff[1] <= rem_in[1];
   end

   assign done   = done_ff;
   assign quot_x = dvd_ff[0];
   assign quot_y = dvd_ff[1];

endmodule

/* hdl/msdp_mul.sv */
module msdp_mul
   import msdp_pkg::*;
#(
   parameter int Z_W = Z_W_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [Z_W-1:0]        op_a,
   input  logic [Z_W-1:0]        op_b,
   output logic                  done,
   output logic [Z_W+((Z_W+DIGIT_W-1)/DIGIT_W)*DIGIT_W-1:0] product
);

   localparam int ND    = (Z_W + DIGIT_W - 1) / DIGIT_W;
   localparam int LO_W  = ND * DIGIT_W;
   localparam int SW    = Z_W + DIGIT_W;
   localparam int CNT_W = (ND > 1) ? $clog2(ND) : 1;

   // one digit of op_b per cycle, low digits first
   logic [Z_W-1:0]   a_ff;
   logic [Z_W-1:0]   a_in;
   logic [LO_W-1:0]  b_ff;
   logic [LO_W-1:0]  b_in;
   logic [Z_W-1:0]   hi_ff;
   logic [Z_W-1:0]   hi_in;
   logic [LO_W-1:0]  lo_ff;
   logic [LO_W-1:0]  lo_in;
   logic [SW-1:0]    part;
   logic [SW-1:0]    sum;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             busy_ff;
   logic             busy_in;
   logic             done_ff;
   logic             done_in;

   assign part = SW'(a_ff) * SW'(b_ff[DIGIT_W-1:0]);
   assign sum  = {{DIGIT_W{1'b0}}, hi_ff} + part;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = op_a;
         b_in    = LO_W'(op_b);
         hi_in   = '0;
         lo_in   = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         lo_in = {sum[DIGIT_W-1:0], lo_ff[LO_W-1:DIGIT_W]};
         hi_in = sum[SW-1:DIGIT_W];
         b_in  = b_ff >> DIGIT_W;
         if (cnt_ff == CNT_W'(ND - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff  <= a_in;
      b_ff  <= b_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};

endmodule

/* hdl/masked_standardized_dot_product_unit.sv */
// masked standardized dot product of two individuals over a run of loci. each
// req item carries one locus: both allele counts (clipped to MAX_COUNT), both
// missing flags and the locus mean and standard deviation with FRAC_BITS
// fraction bits (a deviation of zero counts as 1.0). when neither individual is
// missing, both centred counts are divided by the deviation into Q.24 values on
// a bit-serial divider with two lanes sharing the divisor, multiplied on a
// digit-serial multiplier (8 bits of one operand per cycle), truncated to Q.24
// and added to a saturating signed Q40.24 sum. any clipping of the product or
// of the sum sets the saturated flag. an item with last_locus set gives one rsp
// item with the sum including that locus, then the sum and flag clear; other
// items give nothing. a full locus goes from idle through the divider and
// multiplier states and accumulate back to idle, taking no item meanwhile; the
// divider loop over max(clog2(MAX_COUNT+1)+FRAC_BITS, 16) + 24 quotient bits
// takes most of the time. a locus with a missing genotype goes straight to accumulate.
// one finished result waits in an output register, so work on the next pair
// goes on while rsp_stall is held; only a second last locus waits for it.
module masked_standardized_dot_product_unit
   import msdp_pkg::*;
#(
   parameter int MAX_COUNT = MAX_COUNT_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // widths that follow from the parameters
   localparam int CNT_W = $clog2(MAX_COUNT + 1);
   localparam int CX_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int NUM_W = CNT_W + FRAC_BITS;
   localparam int MAG_W = (NUM_W > MEAN_W) ? NUM_W : MEAN_W;
   localparam int SD_W  = (FRAC_BITS + 1 > MEAN_W) ? FRAC_BITS + 1 : MEAN_W;
   localparam int Z_W   = MAG_W + ACC_FRAC;
   localparam int ND    = (Z_W + DIGIT_W - 1) / DIGIT_W;
   localparam int PRD_W = Z_W + ND * DIGIT_W;
   // product widened so that the bits above the int64 window always exist
   localparam int TOP_B = ACC_FRAC + SUM_W;
   localparam int PX_W  = (PRD_W > TOP_B) ? PRD_W : TOP_B + 1;

   state_type state_ff;
   state_type state_in;

   logic             req_acc;
   logic             skip;
   logic             div_start;
   logic             div_done;
   logic             mul_done;
   logic [Z_W-1:0]   quot_x;
   logic [Z_W-1:0]   quot_y;
   logic [PRD_W-1:0] mul_prod;

   // front end: clip counts, centre on the mean, keep the sign apart
   logic [CX_W-1:0]  cnt_raw [2];
   logic [CX_W-1:0]  cnt_cl  [2];
   logic [MAG_W-1:0] num     [2];
   logic [MAG_W-1:0] mag     [2];
   logic             neg     [2];
   logic [MAG_W-1:0] mean_ext;
   logic [SD_W-1:0]  sd_eff;

   // per-item flags held while the item is worked on
   logic neg_x_ff;
   logic neg_y_ff;
   logic last_ff;
   logic skip_ff;

   // accumulation
   logic [PX_W-1:0]  prod_x;
   logic [SUM_W-1:0] mag64;
   logic             big;
   logic             pneg;
   logic             clip;
   logic [SUM_W-1:0] term;
   logic [SUM_W-1:0] sum;
   logic             add_ovf;
   logic [SUM_W-1:0] new_acc;
   logic             new_ovf;
   logic [SUM_W-1:0] acc_ff;
   logic [SUM_W-1:0] acc_in;
   logic             ovf_ff;
   logic             ovf_in;

   // output register
   logic    out_free;
   logic    load;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign skip      = req_data.x_missing || req_data.y_missing;
   assign div_start = req_acc && !skip;

   assign cnt_raw[0] = CX_W'(req_data.x_count);
   assign cnt_raw[1] = CX_W'(req_data.y_count);
   assign mean_ext   = MAG_W'(req_data.mean_value);
   assign sd_eff     = (req_data.sd_value == '0) ? (SD_W'(1) << FRAC_BITS)
                                                 : SD_W'(req_data.sd_value);

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         cnt_cl[i] = (cnt_raw[i] > CX_W'(MAX_COUNT)) ? CX_W'(MAX_COUNT) : cnt_raw[i];
         num[i]    = MAG_W'(cnt_cl[i]) << FRAC_BITS;
         neg[i]    = (num[i] < mean_ext);
         mag[i]    = neg[i] ? (mean_ext - num[i]) : (num[i] - mean_ext);
      end
   end

   msdp_div #(
      .MAG_W (MAG_W),
      .SD_W  (SD_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .mag_x   (mag[0]),
      .mag_y   (mag[1]),
      .divisor (sd_eff),
      .done    (div_done),
      .quot_x  (quot_x),
      .quot_y  (quot_y)
   );

   // the multiplier starts as the quotients land
   msdp_mul #(
      .Z_W (Z_W)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (div_done),
      .op_a    (quot_x),
      .op_b    (quot_y),
      .done    (mul_done),
      .product (mul_prod)
   );

   // product magnitude >> 24, clipped into the int64 range
   always_comb begin
      prod_x = PX_W'(mul_prod);
      mag64  = prod_x[ACC_FRAC +: SUM_W];
      big    = |prod_x[PX_W-1:TOP_B];
      pneg   = (neg_x_ff ^ neg_y_ff) && (mag64 != '0);
      if (pneg) begin
         clip = big || (mag64 > NEG_MIN);
         term = clip ? NEG_MIN : (~mag64 + SUM_W'(1));
      end else begin
         clip = big || mag64[SUM_W-1];
         term = clip ? POS_MAX : mag64;
      end
      sum     = acc_ff + term;
      add_ovf = (acc_ff[SUM_W-1] == term[SUM_W-1]) && (sum[SUM_W-1] != acc_ff[SUM_W-1]);
      if (skip_ff) begin
         new_acc = acc_ff;
         new_ovf = ovf_ff;
      end else begin
         new_acc = add_ovf ? (acc_ff[SUM_W-1] ? NEG_MIN : POS_MAX) : sum;
         new_ovf = ovf_ff || clip || add_ovf;
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load     = (state_ff == ST_ACC) && last_ff && out_free;

   // sequencer: next state and accumulator update
   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      ovf_in   = ovf_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = skip ? ST_ACC : ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            // a last locus holds here until the output register is free
            if (!last_ff) begin
               state_in = ST_IDLE;
               acc_in   = new_acc;
               ovf_in   = new_ovf;
            end else if (out_free) begin
               state_in = ST_IDLE;
               acc_in   = '0;
               ovf_in   = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item flags and result payload
   always_ff @(posedge clock) begin
      if (req_acc) begin
         neg_x_ff <= neg[0];
         neg_y_ff <= neg[1];
         last_ff  <= req_data.last_locus;
         skip_ff  <= skip;
      end
      if (load) begin
         rsp_data_ff.dot_product <= new_acc;
         rsp_data_ff.saturated   <= new_ovf;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hdl/msdp_chk.sv */
module msdp_chk
   import msdp_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // no result straight out of reset
   a_reset_quiet : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a waiting result holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result dropped or changed");

   // an accepted item keeps the block busy for at least the next cycle
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item accepted back to back");

   // a new result only comes out of work in progress
   a_rsp_from_work : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared while the block was idle");

endmodule

bind masked_standardized_dot_product_unit msdp_chk u_msdp_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

/* tb/masked_standardized_dot_product_unit_tb.sv */
`timescale 1ns / 100ps

module masked_standardized_dot_product_unit_tb;
   import msdp_pkg::*;

   localparam int          RESET_CYCLES = 8;
   localparam int          HOLD_CYCLES  = 1500;
   localparam int          DRAIN_CYCLES = 150;
   localparam int unsigned CYCLE_LIMIT  = 1000000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // loci waiting to be offered, sums still owed by the block
   req_type pending_loci[$];
   rsp_type expected_sums[$];

   // running state of the pair in flight, as the block should hold it
   logic [SUM_W-1:0] run_sum     = '0;
   logic             run_clipped = 1'b0;

   int unsigned send_idle_pct = 6;
   int unsigned recv_idle_pct = 88;
   logic        hold_wanted   = 1'b0;
   logic        hold_done     = 1'b0;
   int unsigned hold_left     = 0;
   int unsigned fault_count   = 0;
   int unsigned cycle_count   = 0;

   masked_standardized_dot_product_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   // magnitude of (count - mean) / sd in Q.24, with the sign as below
   function automatic logic [63:0] deviation_q24(input logic [COUNT_W-1:0] cnt,
                                                  input logic [MEAN_W-1:0]  mean,
                                                  input logic [63:0]        sd,
                                                  output logic              below);
      logic [63:0] num;
      logic [63:0] mag;
      num   = 64'(cnt) << FRAC_BITS_DEF;
      below = num < 64'(mean);
      mag   = below ? 64'(mean) - num : num - 64'(mean);
      return (mag << ACC_FRAC) / sd;
   endfunction

   // fold one accepted locus into the running sum; a last locus owes a sum item
   task automatic add_locus(input req_type it);
      logic [COUNT_W-1:0] xc;
      logic [COUNT_W-1:0] yc;
      logic [63:0]        sd;
      logic [63:0]        zx;
      logic [63:0]        zy;
      logic [63:0]        mag;
      logic [63:0]        term;
      logic [63:0]        total;
      logic [127:0]       prod;
      logic               nx;
      logic               ny;
      logic               big;
      logic               neg;
      rsp_type            owed;
      // counts above the bound are taken as the bound
      xc = (it.x_count > MAX_COUNT_DEF) ? COUNT_W'(MAX_COUNT_DEF) : it.x_count;
      yc = (it.y_count > MAX_COUNT_DEF) ? COUNT_W'(MAX_COUNT_DEF) : it.y_count;
      // zero deviation counts as 1.0
      sd = (it.sd_value == '0) ? (64'd1 << FRAC_BITS_DEF) : 64'(it.sd_value);
      if (!it.x_missing && !it.y_missing) begin
         zx   = deviation_q24(xc, it.mean_value, sd, nx);
         zy   = deviation_q24(yc, it.mean_value, sd, ny);
         prod = (128'(zx) * 128'(zy)) >> ACC_FRAC;
         big  = |prod[127:64];
         mag  = prod[63:0];
         neg  = (nx != ny) && (mag != '0);
         // clip the product to the signed 64-bit range
         if (neg) begin
            if (big || mag > NEG_MIN) begin
               mag         = NEG_MIN;
               run_clipped = 1'b1;
            end
            term = -mag;
         end else begin
            if (big || mag > POS_MAX) begin
               mag         = POS_MAX;
               run_clipped = 1'b1;
            end
            term = mag;
         end
         // saturating add
         total = run_sum + term;
         if (run_sum[63] == term[63] && total[63] != run_sum[63]) begin
            total       = run_sum[63] ? NEG_MIN : POS_MAX;
            run_clipped = 1'b1;
         end
         run_sum = total;
      end
      if (it.last_locus) begin
         owed.dot_product = run_sum;
         owed.saturated   = run_clipped;
         expected_sums.push_back(owed);
         run_sum     = '0;
         run_clipped = 1'b0;
      end
   endtask

   // ---------------------------------------------------------------- stimulus

   function automatic req_type make_locus(input int x, input int y, input bit xm,
                                          input bit ym, input int mean, input int sd,
                                          input bit last);
      req_type it;
      it.x_count    = COUNT_W'(x);
      it.y_count    = COUNT_W'(y);
      it.x_missing  = xm;
      it.y_missing  = ym;
      it.mean_value = MEAN_W'(mean);
      it.sd_value   = MEAN_W'(sd);
      it.last_locus = last;
      return it;
   endfunction

   function automatic req_type random_locus(input bit last);
      req_type it;
      it.x_count    = COUNT_W'(($urandom_range(9) == 0) ? $urandom_range(15, 9)
                                                         : $urandom_range(8, 0));
      it.y_count    = COUNT_W'(($urandom_range(9) == 0) ? $urandom_range(15, 9)
                                                         : $urandom_range(8, 0));
      it.x_missing  = ($urandom_range(99) < 12);
      it.y_missing  = ($urandom_range(99) < 12);
      it.last_locus = last;
      case ($urandom_range(3))
         0: it.mean_value = MEAN_W'($urandom_range(16'h8000, 0));  // plausible means
         1: it.mean_value = MEAN_W'($urandom);
         2: it.mean_value = $urandom_range(1) ? 16'hFFFF : 16'h0000;
         default: it.mean_value = MEAN_W'($urandom_range(8)) << FRAC_BITS_DEF;
      endcase
      case ($urandom_range(3))
         0: it.sd_value = ($urandom_range(1) == 0) ? 16'h0000 : 16'h1000;
         1: it.sd_value = MEAN_W'($urandom_range(15, 1));           // tiny deviations
         2: it.sd_value = MEAN_W'($urandom_range(16'h2000, 16'h0400));
         default: it.sd_value = MEAN_W'($urandom);
      endcase
      return it;
   endfunction

   // random pairs of up to max_len loci, about total loci in all
   task automatic queue_pairs(input int total, input int max_len);
      int count;
      int len;
      count = 0;
      while (count < total) begin
         len = $urandom_range(max_len, 1);
         for (int i = 0; i < len; i++)
            pending_loci.push_back(random_locus(i == len - 1));
         count += len;
      end
   endtask

   // one pair of n identical loci
   task automatic queue_run(input int n, input int x, input int y, input int mean,
                            input int sd);
      for (int i = 0; i < n; i++)
         pending_loci.push_back(make_locus(x, y, 1'b0, 1'b0, mean, sd, i == n - 1));
   endtask

   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_loci.size() != 0 || req_valid || expected_sums.size() != 0);
   endtask

   // ---------------------------------------------------------------- driver

   // offers the next locus whenever the slot is free and the sender is not idling
   always @(posedge clock) begin : drive_loci
      logic    nxt_valid;
      req_type nxt_data;
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else begin
         nxt_valid = req_valid;
         nxt_data  = req_data;
         if (!req_valid || !req_stall) begin
            nxt_valid = 1'b0;
            if (pending_loci.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt_valid = 1'b1;
               nxt_data  = pending_loci.pop_front();
            end
         end
         req_valid <= nxt_valid;
         req_data  <= nxt_data;
      end
   end

   // ---------------------------------------------------------------- hold-off

   // one long receiver hold-off so the output register fills and the input backs up
   always @(posedge clock) begin : hold_off
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_wanted && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
      end
   end

   // ---------------------------------------------------------------- monitor

   // checks sum items first, then books any locus accepted at the same edge
   always @(posedge clock) begin : watch_sums
      logic    nxt_stall;
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_sums.size() == 0) begin
               fault_count++;
               $display("%0t: unexpected sum item, expected none, got %h sat %b",
                        $time, rsp_data.dot_product, rsp_data.saturated);
            end else begin
               want = expected_sums.pop_front();
               if (rsp_data.dot_product !== want.dot_product) begin
                  fault_count++;
                  $display("%0t: dot_product expected %h, got %h",
                           $time, want.dot_product, rsp_data.dot_product);
               end
               if (rsp_data.saturated !== want.saturated) begin
                  fault_count++;
                  $display("%0t: saturated expected %b, got %b",
                           $time, want.saturated, rsp_data.saturated);
               end
            end
         end
         if (req_valid && !req_stall)
            add_locus(req_data);
         if (hold_left != 0)
            nxt_stall = 1'b1;
         else
            nxt_stall = ($urandom_range(99) < recv_idle_pct);
         rsp_stall <= nxt_stall;
      end
   end

   // watchdog
   always @(posedge clock) begin : count_cycles
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin : run_stimulus
      // directed loci: extremes, clipped counts, missing flags, zero deviation
      pending_loci.push_back(make_locus(0, 0, 0, 0, 16'h0000, 16'h0000, 1));
      pending_loci.push_back(make_locus(8, 8, 0, 0, 16'h0000, 16'h0000, 1));
      pending_loci.push_back(make_locus(15, 9, 0, 0, 16'h4000, 16'h1000, 1));
      pending_loci.push_back(make_locus(15, 15, 0, 0, 16'hFFFF, 16'hFFFF, 1));
      pending_loci.push_back(make_locus(0, 8, 0, 0, 16'h4000, 16'h0001, 0));
      pending_loci.push_back(make_locus(3, 5, 0, 1, 16'h2000, 16'h0800, 0));
      // mean sits exactly on a count
      pending_loci.push_back(make_locus(2, 5, 0, 0, 16'h2000, 16'h0800, 0));
      // last locus with both genotypes missing still gives the sum
      pending_loci.push_back(make_locus(7, 1, 1, 1, 16'h1234, 16'h0000, 1));
      pending_loci.push_back(make_locus(4, 4, 1, 0, 16'h0000, 16'h0000, 1));
      pending_loci.push_back(make_locus(8, 0, 0, 0, 16'h0000, 16'hFFFF, 0));
      pending_loci.push_back(make_locus(0, 0, 0, 0, 16'hFFFF, 16'h0001, 0));
      pending_loci.push_back(make_locus(6, 2, 0, 0, 16'h3800, 16'h0000, 1));
      pending_loci.push_back(make_locus(1, 1, 0, 0, 16'h1000, 16'h1000, 1));
      pending_loci.push_back(make_locus(9, 10, 0, 0, 16'h8000, 16'h0002, 1));
      // sender mostly busy, receiver mostly stalling
      queue_pairs(200, 12);
      // positive products big enough to saturate the sum
      queue_run(135, 0, 0, 16'hFFFF, 16'h0001);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      wait_drained();

      // sender mostly idle, receiver mostly ready
      send_idle_pct = 88;
      recv_idle_pct = 6;
      queue_pairs(200, 12);
      wait_drained();

      // no idling; first a burst of short pairs under a long receiver hold-off
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_wanted   = 1'b1;
      queue_pairs(24, 2);
      wait_drained();

      queue_pairs(180, 12);
      // long run of large negative products
      queue_run(100, 0, 8, 16'h4000, 16'h0001);
      wait_drained();

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fault_count == 0 && expected_sums.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
